### hdl/ctsql_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Condition-to-SQL translator package
// Shared types, keyword texts and status codes for the translator blocks.
// ----------------------------------------------------------------------------
package ctsql_pkg;

    // Keyword codes: the fixed texts that the back end expands byte by byte.
    typedef logic [3:0] kw_code_t;

    localparam kw_code_t KW_NONE       = 4'd0;
    localparam kw_code_t KW_WHERE      = 4'd1;
    localparam kw_code_t KW_GLOB       = 4'd2;
    localparam kw_code_t KW_OR         = 4'd3;
    localparam kw_code_t KW_AND        = 4'd4;
    localparam kw_code_t KW_NAME       = 4'd5;
    localparam kw_code_t KW_ORIGIN     = 4'd6;
    localparam kw_code_t KW_PREFIX     = 4'd7;
    localparam kw_code_t KW_MAINTAINER = 4'd8;
    localparam kw_code_t KW_COMMENT    = 4'd9;
    localparam kw_code_t KW_WWW        = 4'd10;
    localparam kw_code_t KW_FLATSIZE   = 4'd11;
    localparam kw_code_t KW_AUTOMATIC  = 4'd12;
    localparam kw_code_t KW_MESSAGE    = 4'd13;
    localparam kw_code_t KW_INFOS      = 4'd14;
    localparam kw_code_t KW_TIME       = 4'd15;

    // Status codes reported on the output.
    typedef logic [2:0] status_t;

    localparam status_t ST_OK          = 3'd0;
    localparam status_t ST_SEMICOLON   = 3'd1;
    localparam status_t ST_BAD_FIELD   = 3'd2;
    localparam status_t ST_UNEXPECTED  = 3'd3;
    localparam status_t ST_TILDE_INT   = 3'd4;
    localparam status_t ST_CMP_STRING  = 3'd5;
    localparam status_t ST_BANG        = 3'd6;
    localparam status_t ST_NUMBER      = 3'd7;

    // Depth of the command queue between front and back end.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One command: everything a single input word makes the back end emit,
    // in order: keyword text, up to three literal bytes, a status result.
    typedef struct packed {
        kw_code_t        kw;
        logic [1:0]      lit_cnt;
        logic [2:0][7:0] lit;
        logic            stat_en;
        status_t         stat_code;
        logic            last;
    } cmd_t;

    // Number of bytes in a keyword text.
    function automatic logic [3:0] kw_len(kw_code_t kw);
        logic [3:0] len;
        unique case (kw)
            KW_WHERE:      len = 4'd7;
            KW_GLOB:       len = 4'd6;
            KW_OR:         len = 4'd4;
            KW_AND:        len = 4'd5;
            KW_NAME:       len = 4'd4;
            KW_ORIGIN:     len = 4'd6;
            KW_PREFIX:     len = 4'd6;
            KW_MAINTAINER: len = 4'd10;
            KW_COMMENT:    len = 4'd7;
            KW_WWW:        len = 4'd3;
            KW_FLATSIZE:   len = 4'd8;
            KW_AUTOMATIC:  len = 4'd9;
            KW_MESSAGE:    len = 4'd7;
            KW_INFOS:      len = 4'd5;
            KW_TIME:       len = 4'd4;
            default:       len = 4'd0;
        endcase
        return len;
    endfunction

    // Keyword text, left aligned and padded to ten characters.
    function automatic logic [79:0] kw_text(kw_code_t kw);
        logic [79:0] txt;
        unique case (kw)
            KW_WHERE:      txt = " WHERE    ";
            KW_GLOB:       txt = " GLOB     ";
            KW_OR:         txt = " OR       ";
            KW_AND:        txt = " AND      ";
            KW_NAME:       txt = "name      ";
            KW_ORIGIN:     txt = "origin    ";
            KW_PREFIX:     txt = "prefix    ";
            KW_MAINTAINER: txt = "maintainer";
            KW_COMMENT:    txt = "comment   ";
            KW_WWW:        txt = "www       ";
            KW_FLATSIZE:   txt = "flatsize  ";
            KW_AUTOMATIC:  txt = "automatic ";
            KW_MESSAGE:    txt = "message   ";
            KW_INFOS:      txt = "infos     ";
            KW_TIME:       txt = "time      ";
            default:       txt = '0;
        endcase
        return txt;
    endfunction

    // Byte at a position (0 to 9) of a keyword text.
    function automatic logic [7:0] kw_byte(kw_code_t kw, logic [3:0] idx);
        logic [79:0] txt;
        logic [3:0]  sh;
        txt = kw_text(kw);
        sh  = 4'd9 - idx;
        return txt[{sh, 3'b000} +: 8];
    endfunction

endpackage

### hdl/ctsql_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Condition input channel
// Carries one character of the condition expression per word.
// ----------------------------------------------------------------------------
interface ctsql_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);

endinterface

### hdl/ctsql_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SQL output channel
// Carries one SQL text byte or one status result per word.
// ----------------------------------------------------------------------------
interface ctsql_out_if;

    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_valid;
    logic       out_last;
    logic [2:0] status;

    modport source (output valid, output out_char, output out_valid, output out_last,
                    output status, input ready);
    modport sink   (input valid, input out_char, input out_valid, input out_last,
                    input status, output ready);

endinterface

### hdl/condition_to_sql_translator.sv
`timescale 1ns / 1ps
// The first result word of a character passes through the command queue and then
// the registered output stage, when the queue and output stage are empty.
// Throughput: one output word per cycle, unless the output holds ready low, from the back
// end's single output register; a character causes from 0 to 10 words.
// A four-entry command queue lets input run ahead during keyword bursts.
// Reset: asynchronous, active low; parser returns to start and the queue empties.
// ----------------------------------------------------------------------------
// Condition-to-SQL translator
// Translates a condition expression into the text of an SQL WHERE clause.
// ----------------------------------------------------------------------------
module condition_to_sql_translator (
    input  logic        clk,
    input  logic        rst_n,
    ctsql_in_if.sink    cond,
    ctsql_out_if.source sql
);
    import ctsql_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_nonempty;
    cmd_t q_in;
    cmd_t q_head;

    ctsql_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .push  (q_push),
        .cmd   (q_in),
        .full  (q_full)
    );

    ctsql_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .nonempty (q_nonempty)
    );

    ctsql_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .nonempty (q_nonempty),
        .pop      (q_pop),
        .sql      (sql)
    );

    // A byte word always carries an ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sql.valid && sql.out_valid) |-> (sql.status == ST_OK))
        else $error("byte word carries a non-zero status");

    // With nothing queued and nothing shown, no word can appear next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!q_nonempty && !sql.valid) |=> !sql.valid)
        else $error("output word appeared without a queued command");

    // A full queue holds the input off.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !cond.ready)
        else $error("input accepted while command queue is full");

    // Commands are only taken from a queue that holds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_nonempty)
        else $error("command taken from an empty queue");

endmodule

### hdl/ctsql_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Translator front end
// Accepts characters, runs the parser state machine and turns each character
// into at most one command for the back end.
// ----------------------------------------------------------------------------
module ctsql_front (
    input  logic             clk,
    input  logic             rst_n,
    ctsql_in_if.sink         cond,
    output logic             push,
    output ctsql_pkg::cmd_t  cmd,
    input  logic             full
);
    import ctsql_pkg::*;

    // Parser phases.
    localparam logic [4:0] MD_START = 5'd0;
    localparam logic [4:0] MD_IDLE  = 5'd1;
    localparam logic [4:0] MD_FIELD = 5'd2;
    localparam logic [4:0] MD_OR    = 5'd3;
    localparam logic [4:0] MD_AND   = 5'd4;
    localparam logic [4:0] MD_OPS   = 5'd5;
    localparam logic [4:0] MD_OPI   = 5'd6;
    localparam logic [4:0] MD_EQS   = 5'd7;
    localparam logic [4:0] MD_EQI   = 5'd8;
    localparam logic [4:0] MD_BANGS = 5'd9;
    localparam logic [4:0] MD_BANGI = 5'd10;
    localparam logic [4:0] MD_VALS  = 5'd11;
    localparam logic [4:0] MD_VALI  = 5'd12;
    localparam logic [4:0] MD_NUM   = 5'd13;
    localparam logic [4:0] MD_BARE  = 5'd14;
    localparam logic [4:0] MD_DQ    = 5'd15;
    localparam logic [4:0] MD_SQ    = 5'd16;

    // Characters with a meaning to the parser.
    localparam logic [7:0] CH_SEMI  = ";";
    localparam logic [7:0] CH_PCT   = "%";
    localparam logic [7:0] CH_BAR   = "|";
    localparam logic [7:0] CH_AMP   = "&";
    localparam logic [7:0] CH_BANG  = "!";
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_LT    = "<";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_TILDE = "~";
    localparam logic [7:0] CH_DQ    = "\"";
    localparam logic [7:0] CH_SQ    = "'";
    localparam logic [7:0] CH_LPAR  = "(";
    localparam logic [7:0] CH_RPAR  = ")";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";

    logic [4:0] mode_reg, mode_next;
    logic       failed_reg, failed_next;
    status_t    fail_code_reg, fail_code_next;

    logic            accept;
    logic            c_ws;
    logic            c_dig;
    logic [4:0]      m;
    kw_code_t        kw;
    kw_code_t        col;
    logic            col_int;
    logic [2:0][7:0] lit;
    logic [1:0]      n;
    status_t         err;
    logic            go;
    logic            stat_en;
    status_t         stat_code;

    // Column keyword selected by the character after a field marker.
    function automatic kw_code_t col_lookup(logic [7:0] ch);
        kw_code_t k;
        unique case (ch)
            "n":     k = KW_NAME;
            "o":     k = KW_ORIGIN;
            "p":     k = KW_PREFIX;
            "m":     k = KW_MAINTAINER;
            "c":     k = KW_COMMENT;
            "w":     k = KW_WWW;
            "s":     k = KW_FLATSIZE;
            "a":     k = KW_AUTOMATIC;
            "M":     k = KW_MESSAGE;
            "i":     k = KW_INFOS;
            "t":     k = KW_TIME;
            default: k = KW_NONE;
        endcase
        return k;
    endfunction

    assign cond.ready = !full;
    assign accept     = cond.valid && !full;

    assign c_ws  = (cond.in_char == CH_SPACE) ||
                   (cond.in_char >= CH_TAB && cond.in_char <= CH_CR);
    assign c_dig = (cond.in_char >= CH_ZERO) && (cond.in_char <= CH_NINE);

    assign col     = col_lookup(cond.in_char);
    assign col_int = (col == KW_FLATSIZE) || (col == KW_AUTOMATIC) || (col == KW_TIME);

    // Parser: works out the next phase and the bytes this character produces.
    always_comb
    begin
        m         = mode_reg;
        kw        = KW_NONE;
        lit       = '0;
        n         = 2'd0;
        err       = ST_OK;
        go        = 1'b0;
        stat_en   = 1'b0;
        stat_code = ST_OK;

        // The first character of an expression opens the clause.
        if (mode_reg == MD_START)
        begin
            kw = KW_WHERE;
            m  = MD_IDLE;
        end

        if (!failed_reg)
        begin
            // Phases that look at the character before anything else.
            case (m)
                MD_FIELD:
                begin
                    if (col == KW_NONE)
                    begin
                        err = ST_BAD_FIELD;
                    end
                    else
                    begin
                        kw = col;
                        m  = col_int ? MD_OPI : MD_OPS;
                    end
                end
                MD_OR:
                begin
                    if (cond.in_char != CH_BAR)
                    begin
                        err = ST_UNEXPECTED;
                    end
                    else
                    begin
                        kw = KW_OR;
                        m  = MD_IDLE;
                    end
                end
                MD_AND:
                begin
                    if (cond.in_char != CH_AMP)
                    begin
                        err = ST_UNEXPECTED;
                    end
                    else
                    begin
                        kw = KW_AND;
                        m  = MD_IDLE;
                    end
                end
                MD_BANGS, MD_BANGI:
                begin
                    if (cond.in_char != CH_EQ)
                    begin
                        err = ST_BANG;
                    end
                    else
                    begin
                        lit[0] = CH_BANG;
                        lit[1] = CH_EQ;
                        n      = 2'd2;
                        m      = (m == MD_BANGS) ? MD_VALS : MD_VALI;
                    end
                end
                MD_EQS, MD_EQI:
                begin
                    m = (m == MD_EQS) ? MD_VALS : MD_VALI;
                    if (cond.in_char == CH_EQ)
                    begin
                        lit[0] = CH_EQ;
                        n      = 2'd1;
                    end
                    else
                    begin
                        go = 1'b1;
                    end
                end
                default:
                begin
                    go = 1'b1;
                end
            endcase

            if (go)
            begin
                if (cond.in_char == CH_SEMI)
                begin
                    err = ST_SEMICOLON;
                end
                else
                begin
                    case (m)
                        MD_OPS, MD_OPI:
                        begin
                            if (c_ws)
                            begin
                                lit[0] = cond.in_char;
                                n      = 2'd1;
                            end
                            else if (cond.in_char == CH_TILDE)
                            begin
                                if (m == MD_OPI)
                                begin
                                    err = ST_TILDE_INT;
                                end
                                else
                                begin
                                    kw = KW_GLOB;
                                    m  = MD_VALS;
                                end
                            end
                            else if (cond.in_char == CH_LT || cond.in_char == CH_GT)
                            begin
                                if (m == MD_OPS)
                                begin
                                    err = ST_CMP_STRING;
                                end
                                else
                                begin
                                    lit[0] = cond.in_char;
                                    n      = 2'd1;
                                    m      = MD_EQI;
                                end
                            end
                            else if (cond.in_char == CH_EQ)
                            begin
                                lit[0] = cond.in_char;
                                n      = 2'd1;
                                m      = (m == MD_OPI) ? MD_EQI : MD_EQS;
                            end
                            else if (cond.in_char == CH_BANG)
                            begin
                                m = (m == MD_OPI) ? MD_BANGI : MD_BANGS;
                            end
                        end
                        MD_VALS:
                        begin
                            if (c_ws)
                            begin
                                lit[0] = cond.in_char;
                                n      = 2'd1;
                            end
                            else
                            begin
                                lit[0] = CH_SQ;
                                n      = 2'd1;
                                if (cond.in_char == CH_DQ)
                                begin
                                    m = MD_DQ;
                                end
                                else if (cond.in_char == CH_SQ)
                                begin
                                    m = MD_SQ;
                                end
                                else
                                begin
                                    lit[1] = cond.in_char;
                                    n      = 2'd2;
                                    m      = MD_BARE;
                                end
                            end
                        end
                        MD_VALI:
                        begin
                            if (c_ws)
                            begin
                                lit[0] = cond.in_char;
                                n      = 2'd1;
                            end
                            else if (!c_dig)
                            begin
                                err = ST_NUMBER;
                            end
                            else
                            begin
                                lit[0] = cond.in_char;
                                n      = 2'd1;
                                m      = MD_NUM;
                            end
                        end
                        MD_NUM:
                        begin
                            if (c_ws)
                            begin
                                lit[0] = cond.in_char;
                                n      = 2'd1;
                                m      = MD_IDLE;
                            end
                            else if (!c_dig)
                            begin
                                err = ST_NUMBER;
                            end
                            else
                            begin
                                lit[0] = cond.in_char;
                                n      = 2'd1;
                            end
                        end
                        MD_BARE, MD_DQ, MD_SQ:
                        begin
                            if ((m == MD_BARE && c_ws) ||
                                (m == MD_DQ && cond.in_char == CH_DQ) ||
                                (m == MD_SQ && cond.in_char == CH_SQ))
                            begin
                                lit[0] = CH_SQ;
                                n      = 2'd1;
                                m      = MD_IDLE;
                            end
                            else
                            begin
                                // Single quotes inside a value are doubled.
                                lit[0] = cond.in_char;
                                lit[1] = cond.in_char;
                                n      = (cond.in_char == CH_SQ) ? 2'd2 : 2'd1;
                            end
                        end
                        default:
                        begin
                            m = MD_IDLE;
                            if (cond.in_char == CH_PCT)
                            begin
                                m = MD_FIELD;
                            end
                            else if (cond.in_char == CH_LPAR || cond.in_char == CH_RPAR ||
                                     cond.in_char == CH_SPACE || cond.in_char == CH_TAB)
                            begin
                                lit[0] = cond.in_char;
                                n      = 2'd1;
                            end
                            else if (cond.in_char == CH_BAR)
                            begin
                                m = MD_OR;
                            end
                            else if (cond.in_char == CH_AMP)
                            begin
                                m = MD_AND;
                            end
                            else
                            begin
                                err = ST_UNEXPECTED;
                            end
                        end
                    endcase
                end
            end

            // End of input: pending phases either fail or close.
            if (err == ST_OK && cond.in_last)
            begin
                case (m)
                    MD_FIELD:         err = ST_BAD_FIELD;
                    MD_OR, MD_AND:    err = ST_UNEXPECTED;
                    MD_BANGS, MD_BANGI: err = ST_BANG;
                    MD_BARE:
                    begin
                        lit[n] = CH_SQ;
                        n      = n + 2'd1;
                    end
                    default:          ;
                endcase
            end

            if (err != ST_OK)
            begin
                stat_en   = 1'b1;
                stat_code = err;
            end
        end

        // A final character that produced nothing still gets one result.
        if (cond.in_last && kw == KW_NONE && n == 2'd0 && !stat_en)
        begin
            stat_en   = 1'b1;
            stat_code = failed_reg ? fail_code_reg : ST_OK;
        end
    end

    // Command to the queue; characters that produce nothing are not queued.
    always_comb
    begin
        cmd.kw        = kw;
        cmd.lit_cnt   = n;
        cmd.lit       = lit;
        cmd.stat_en   = stat_en;
        cmd.stat_code = stat_code;
        cmd.last      = cond.in_last;
    end

    assign push = accept && (kw != KW_NONE || n != 2'd0 || stat_en);

    // Parser state update on each accepted word.
    always_comb
    begin
        mode_next      = mode_reg;
        failed_next    = failed_reg;
        fail_code_next = fail_code_reg;
        if (accept)
        begin
            if (cond.in_last)
            begin
                mode_next      = MD_START;
                failed_next    = 1'b0;
                fail_code_next = ST_OK;
            end
            else
            begin
                mode_next = m;
                if (err != ST_OK)
                begin
                    failed_next    = 1'b1;
                    fail_code_next = err;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MD_START;
            failed_reg    <= 1'b0;
            fail_code_reg <= ST_OK;
        end
        else
        begin
            mode_reg      <= mode_next;
            failed_reg    <= failed_next;
            fail_code_reg <= fail_code_next;
        end
    end

endmodule

### hdl/ctsql_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Translator command queue
// Short FIFO of commands between the front and back end.
// ----------------------------------------------------------------------------
module ctsql_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ctsql_pkg::cmd_t  push_cmd,
    output logic             full,
    input  logic             pop,
    output ctsql_pkg::cmd_t  head,
    output logic             nonempty
);
    import ctsql_pkg::*;

    cmd_t                entries_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = entries_reg[rd_ptr_reg];

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hdl/ctsql_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Translator back end
// Expands the command at the head of the queue into output words, one per
// cycle while the output is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module ctsql_back (
    input  logic             clk,
    input  logic             rst_n,
    input  ctsql_pkg::cmd_t  head,
    input  logic             nonempty,
    output logic             pop,
    ctsql_out_if.source      sql
);
    import ctsql_pkg::*;

    logic [3:0] pos_reg, pos_next;
    logic       ovalid_reg, ovalid_next;
    logic [7:0] char_reg, char_next;
    logic       byte_reg, byte_next;
    logic       last_reg, last_next;
    status_t    status_reg, status_next;

    logic [3:0] klen;
    logic [3:0] rest;
    logic [3:0] total;
    logic       fin;
    logic       load;

    assign klen  = kw_len(head.kw);
    assign rest  = pos_reg - klen;
    assign total = klen + {2'b00, head.lit_cnt} + {3'b000, head.stat_en};
    assign fin   = (pos_reg == total - 4'd1);
    assign load  = nonempty && (!ovalid_reg || sql.ready);
    assign pop   = load && fin;

    // Pick the word at the current position: keyword, literal or status.
    always_comb
    begin
        char_next   = char_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        status_next = status_reg;
        if (load)
        begin
            last_next = head.last && fin;
            if (pos_reg < klen)
            begin
                char_next   = kw_byte(head.kw, pos_reg);
                byte_next   = 1'b1;
                status_next = ST_OK;
            end
            else if (rest < {2'b00, head.lit_cnt})
            begin
                char_next   = head.lit[rest[1:0]];
                byte_next   = 1'b1;
                status_next = ST_OK;
            end
            else
            begin
                char_next   = 8'd0;
                byte_next   = 1'b0;
                status_next = head.stat_code;
            end
        end
    end

    // Output handshake and position within the command.
    always_comb
    begin
        ovalid_next = ovalid_reg;
        pos_next    = pos_reg;
        if (load)
        begin
            ovalid_next = 1'b1;
            pos_next    = fin ? 4'd0 : pos_reg + 4'd1;
        end
        else if (sql.ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            pos_reg    <= 4'd0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg   <= char_next;
        byte_reg   <= byte_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    assign sql.valid     = ovalid_reg;
    assign sql.out_char  = char_reg;
    assign sql.out_valid = byte_reg;
    assign sql.out_last  = last_reg;
    assign sql.status    = status_reg;

endmodule
